/* rtl/core/ssd_pkg.sv */
// Shared types, symbol codes and the segment decode table for the display driver.
package ssd_pkg;

   // Command codes carried by one request transaction.
   typedef enum logic [1:0] {
      CMD_SET_DIGIT   = 2'd0,
      CMD_SHOW_NUMBER = 2'd1,
      CMD_SCAN_TICK   = 2'd2
   } cmd_type;

   // Symbol codes held in the digit buffer.
   localparam logic [4:0] CODE_MINUS = 5'd16;
   localparam logic [4:0] CODE_BLANK = 5'd18;

   // Multiplier for divide-by-ten: q = (x * RECIP10) >> RECIP_SHIFT, exact for x < 81920.
   localparam logic [15:0] RECIP10     = 16'hCCCD;
   localparam int          RECIP_SHIFT = 19;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_set;     // store one symbol code at one position
      logic load_number;   // blank the buffer and capture sign and magnitude
      logic convert_step;  // write one decimal digit and divide by ten
      logic write_sign;    // place the minus sign above the top digit when negative
      logic emit_blank;    // drive the blanking result
      logic emit_pattern;  // drive the pattern result and advance the scan
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic quot_zero;     // the current division step leaves nothing above it
   } dp_status_type;

   // Segment pattern for one symbol code; a-g in bits 0-6, point in bit 7.
   function automatic logic [7:0] seg_pattern(input logic [4:0] code);
      logic [7:0] pat;
      unique case (code)
         5'd0:    pat = 8'h3F;
         5'd1:    pat = 8'h06;
         5'd2:    pat = 8'h5B;
         5'd3:    pat = 8'h4F;
         5'd4:    pat = 8'h66;
         5'd5:    pat = 8'h6D;
         5'd6:    pat = 8'h7D;
         5'd7:    pat = 8'h07;
         5'd8:    pat = 8'h7F;
         5'd9:    pat = 8'h6F;
         5'd10:   pat = 8'h77;
         5'd11:   pat = 8'h7C;
         5'd12:   pat = 8'h39;
         5'd13:   pat = 8'h5E;
         5'd14:   pat = 8'h79;
         5'd15:   pat = 8'h71;
         5'd16:   pat = 8'h40;
         5'd17:   pat = 8'h80;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

/* rtl/core/ssd_ctrl.sv */
// Controller state machine that sequences set, conversion and scan transactions.
module ssd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_command,
   input  ssd_pkg::dp_status_type status,
   output ssd_pkg::dp_cmd_type    cmd,
   output logic                  busy
);
   import ssd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd_type'(req_command))
                  CMD_SET_DIGIT: begin
                     cmd.write_set = 1'b1;
                  end
                  CMD_SHOW_NUMBER: begin
                     cmd.load_number = 1'b1;
                     state_in        = ST_CONVERT;
                  end
                  CMD_SCAN_TICK: begin
                     cmd.emit_blank = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            cmd.convert_step = 1'b1;
            if (status.quot_zero) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            cmd.write_sign = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.emit_pattern = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // State and registered busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* rtl/core/ssd_datapath.sv */
// Datapath: digit buffer, divide-by-ten converter, scan counter and result registers.
module ssd_datapath #(
   parameter int NUM_DIGITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ssd_pkg::dp_cmd_type     cmd,
   output ssd_pkg::dp_status_type  status,
   input  logic [2:0]             req_digit_position,
   input  logic [7:0]             req_symbol_code,
   input  logic signed [15:0]     req_number,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_digit_select,
   output logic [7:0]             rsp_segments,
   output logic                   rsp_last_of_run
);
   import ssd_pkg::*;

   localparam int          POS_W   = $clog2(NUM_DIGITS);
   localparam logic [3:0]  NUM_LIM = 4'(NUM_DIGITS);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

   logic [4:0]       buf_ff [NUM_DIGITS];
   logic [4:0]       buf_in [NUM_DIGITS];
   logic [POS_W-1:0] scan_ff, scan_in;
   logic [16:0]      mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [2:0]       conv_pos_ff, conv_pos_in;
   logic             strobe_ff, strobe_in;
   logic [2:0]       sel_ff, sel_in;
   logic [7:0]       seg_ff, seg_in;
   logic             last_ff, last_in;

   logic [32:0]      prod;
   logic [16:0]      quot;
   logic [16:0]      quot10;
   logic [16:0]      rem_full;
   logic             set_in_range;
   logic             conv_in_range;
   logic [4:0]       set_code;

   // One divide-by-ten step on the magnitude.
   assign prod     = 33'(mag_ff) * 33'(RECIP10);
   assign quot     = {3'b000, prod[32:RECIP_SHIFT]};
   assign quot10   = (quot << 3) + (quot << 1);
   assign rem_full = mag_ff - quot10;
   assign status.quot_zero = (quot == 17'd0);

   // Range checks and code clamp for buffer writes.
   assign set_in_range  = ({1'b0, req_digit_position} < NUM_LIM);
   assign conv_in_range = ({1'b0, conv_pos_ff} < NUM_LIM);
   assign set_code      = (req_symbol_code > 8'(CODE_BLANK)) ? CODE_BLANK
                                                             : req_symbol_code[4:0];

   // Next values of the buffer and the conversion registers.
   always_comb begin
      buf_in      = buf_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      conv_pos_in = conv_pos_ff;
      if (cmd.write_set && set_in_range) begin
         buf_in[req_digit_position[POS_W-1:0]] = set_code;
      end
      if (cmd.load_number) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            buf_in[i] = CODE_BLANK;
         end
         neg_in      = req_number[15];
         mag_in      = req_number[15] ? 17'(-{req_number[15], req_number})
                                      : {1'b0, req_number};
         conv_pos_in = 3'd0;
      end
      if (cmd.convert_step) begin
         if (conv_in_range) begin
            buf_in[conv_pos_ff[POS_W-1:0]] = {1'b0, rem_full[3:0]};
         end
         mag_in      = quot;
         conv_pos_in = conv_pos_ff + 3'd1;
      end
      if (cmd.write_sign && neg_ff && conv_in_range) begin
         buf_in[conv_pos_ff[POS_W-1:0]] = CODE_MINUS;
      end
   end

   // Next values of the scan counter and the result registers.
   always_comb begin
      scan_in   = scan_ff;
      strobe_in = 1'b0;
      sel_in    = sel_ff;
      seg_in    = seg_ff;
      last_in   = 1'b0;
      if (cmd.emit_blank) begin
         strobe_in = 1'b1;
         sel_in    = 3'(scan_ff);
         seg_in    = 8'h00;
      end
      if (cmd.emit_pattern) begin
         strobe_in = 1'b1;
         sel_in    = 3'(scan_ff);
         seg_in    = seg_pattern(buf_ff[scan_ff]);
         last_in   = 1'b1;
         scan_in   = (scan_ff == POS_LAST) ? '0 : scan_ff + 1'b1;
      end
   end

   // Control state, including the buffer, which resets to blank.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            buf_ff[i] <= CODE_BLANK;
         end
         scan_ff   <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         buf_ff    <= buf_in;
         scan_ff   <= scan_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      conv_pos_ff <= conv_pos_in;
      sel_ff      <= sel_in;
      seg_ff      <= seg_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_digit_select = sel_ff;
   assign rsp_segments     = seg_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

/* rtl/core/seven_segment_mux_display_top.sv */
// Top level of the multiplexed eight-digit seven-segment display driver.
//
//   Channel   Ports                       Transaction taken when
//   request   start, busy, req_*          start high and busy low at a clock edge
//   result    rsp_strobe, rsp_*           rsp_strobe high at a clock edge (no stall)
//
// A set_digit transaction leaves busy low.
// A scan_tick yields two results: the blanking result appears the cycle after
// acceptance and the pattern result, with rsp_last_of_run high, the cycle after that.
// A show_number blanks the buffer, then the divide-by-ten unit yields d decimal digits
// (1 to 5) at one digit per cycle, and a last step places the minus sign if negative.
// Reset is synchronous and blanks the whole buffer and zeroes the scan position.
module seven_segment_mux_display_top #(
   parameter int NUM_DIGITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [2:0]         req_digit_position,
   input  logic [7:0]         req_symbol_code,
   input  logic signed [15:0] req_number,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_digit_select,
   output logic [7:0]         rsp_segments,
   output logic               rsp_last_of_run
);
   import ssd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing.
   ssd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Storage, conversion and result registers.
   ssd_datapath #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_digit_position (req_digit_position),
      .req_symbol_code    (req_symbol_code),
      .req_number         (req_number),
      .rsp_strobe         (rsp_strobe),
      .rsp_digit_select   (rsp_digit_select),
      .rsp_segments       (rsp_segments),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // A scan transaction produces its blanking result in the next cycle.
   a_scan_blank: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_SCAN_TICK) |=>
         (rsp_strobe && !rsp_last_of_run && rsp_segments == 8'h00))
      else $error("scan transaction did not produce a blanking result");

   // A pattern result follows the blanking result for the same position.
   a_pattern_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_of_run) |->
         ($past(rsp_strobe) && !$past(rsp_last_of_run)
          && $past(rsp_digit_select) == rsp_digit_select))
      else $error("pattern result without a matching blanking result");

   // The scan never drives a position outside the display.
   a_select_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_digit_select} < 4'(NUM_DIGITS)))
      else $error("digit select outside the display");

endmodule
